// ----- hdl/lpxf_pkg.sv -----
// ----------------------------------------------------------------------------
// lpxf_pkg
// Shared types and constants for the length-prefixed XOR framer.
// ----------------------------------------------------------------------------
package lpxf_pkg;

   localparam logic [7:0] START_BYTE = 8'hA5;
   localparam logic [7:0] END_BYTE   = 8'h5A;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   localparam logic [7:0]  MODULE_ID_RESET    = 8'd1;
   localparam logic [15:0] BUFFER_LIMIT_RESET = 16'hFFFF;

   // frame overhead: start, module, four length bytes, check, end
   localparam logic [16:0] FRAME_OVERHEAD = 17'd8;

   // register index, taken from paddr[2]
   localparam logic REG_MODULE_ID    = 1'b0;
   localparam logic REG_BUFFER_LIMIT = 1'b1;

   // position of an output word within the words one input word causes
   typedef logic [3:0] step_type;
   localparam step_type STEP_START   = 4'd0;
   localparam step_type STEP_MODULE  = 4'd1;
   localparam step_type STEP_LEN0    = 4'd2;
   localparam step_type STEP_LEN1    = 4'd3;
   localparam step_type STEP_LEN2    = 4'd4;
   localparam step_type STEP_LEN3    = 4'd5;
   localparam step_type STEP_PAYLOAD = 4'd6;
   localparam step_type STEP_CHECK   = 4'd7;
   localparam step_type STEP_END     = 4'd8;

   typedef struct packed {
      logic [7:0]  module_id;
      logic [15:0] buffer_limit;
   } cfg_type;

   // everything the emitter needs to expand one input word
   typedef struct packed {
      logic        first;
      logic        last;
      logic [7:0]  payload;
      logic [7:0]  module_id;
      logic [15:0] length;
      logic [7:0]  check;
      logic        oversize;
   } desc_type;

endpackage

// ----- hdl/lpxf_csr.sv -----
// ----------------------------------------------------------------------------
// lpxf_csr
// APB-style register file: module byte and buffer limit.
// ----------------------------------------------------------------------------
module lpxf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output lpxf_pkg::cfg_type cfg
);
   import lpxf_pkg::*;

   logic [7:0]  module_id_ff, module_id_in;
   logic [15:0] buffer_limit_ff, buffer_limit_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      module_id_in    = module_id_ff;
      buffer_limit_in = buffer_limit_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_MODULE_ID:    module_id_in    = csr_pwdata[7:0];
            REG_BUFFER_LIMIT: buffer_limit_in = csr_pwdata[15:0];
            default:          module_id_in    = module_id_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_id_ff    <= MODULE_ID_RESET;
         buffer_limit_ff <= BUFFER_LIMIT_RESET;
      end else begin
         module_id_ff    <= module_id_in;
         buffer_limit_ff <= buffer_limit_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODULE_ID:    csr_prdata = {24'd0, module_id_ff};
         REG_BUFFER_LIMIT: csr_prdata = {16'd0, buffer_limit_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.module_id    = module_id_ff;
   assign cfg.buffer_limit = buffer_limit_ff;

endmodule

// ----- hdl/lpxf_frame.sv -----
// ----------------------------------------------------------------------------
// lpxf_frame
// Frame tracking: remaining count, running XOR and oversize decision.
// ----------------------------------------------------------------------------
module lpxf_frame (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         payload_byte,
   input  logic [15:0]        payload_length,
   input  lpxf_pkg::cfg_type  cfg,
   output lpxf_pkg::desc_type desc
);
   import lpxf_pkg::*;

   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  xor_ff, xor_in;
   logic        over_ff, over_in;

   logic        first;
   logic [15:0] length;
   logic [15:0] count;
   logic [7:0]  check;
   logic        over_cur;
   logic        last;

   always_comb begin
      first  = (remaining_ff == 16'd0);
      // zero length forms a one-byte frame
      length = (payload_length == 16'd0) ? 16'd1 : payload_length;
      count  = (first ? length : remaining_ff) - 16'd1;
      last   = (count == 16'd0);
      check  = (first ? 8'd0 : xor_ff) ^ payload_byte;
      over_cur = first ? (({1'b0, length} + FRAME_OVERHEAD) > {1'b0, cfg.buffer_limit})
                       : over_ff;
   end

   always_comb begin
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      over_in      = over_ff;
      if (accept) begin
         remaining_in = count;
         xor_in       = last ? 8'd0 : check;
         over_in      = last ? 1'b0 : over_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 16'd0;
         xor_ff       <= 8'd0;
         over_ff      <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
         over_ff      <= over_in;
      end
   end

   assign desc.first     = first;
   assign desc.last      = last;
   assign desc.payload   = payload_byte;
   assign desc.module_id = cfg.module_id;
   assign desc.length    = length;
   assign desc.check     = check;
   assign desc.oversize  = over_cur;

endmodule

// ----- hdl/lpxf_emitter.sv -----
// ----------------------------------------------------------------------------
// lpxf_emitter
// Holds one expanded input word and steps its output words into the
// output register, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lpxf_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  lpxf_pkg::desc_type desc,
   output logic               take_ok,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [1:0]         rsp_tuser
);
   import lpxf_pkg::*;

   desc_type   desc_ff, desc_in;
   logic       held_ff, held_in;
   step_type   step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [1:0] user_ff, user_in;

   logic       out_free;
   logic       move;
   step_type   end_step;
   logic [7:0] sel_byte;

   assign out_free = ~valid_ff | rsp_tready;
   assign move     = held_ff & out_free;
   assign end_step = desc_ff.last ? STEP_END : STEP_PAYLOAD;
   assign take_ok  = ~held_ff | (out_free & (step_ff == end_step));

   always_comb begin
      case (step_ff)
         STEP_START:   sel_byte = START_BYTE;
         STEP_MODULE:  sel_byte = desc_ff.module_id;
         STEP_LEN0:    sel_byte = desc_ff.length[7:0];
         STEP_LEN1:    sel_byte = desc_ff.length[15:8];
         STEP_LEN2:    sel_byte = ZERO_BYTE;
         STEP_LEN3:    sel_byte = ZERO_BYTE;
         STEP_PAYLOAD: sel_byte = desc_ff.payload;
         STEP_CHECK:   sel_byte = desc_ff.check;
         STEP_END:     sel_byte = END_BYTE;
         default:      sel_byte = ZERO_BYTE;
      endcase
   end

   always_comb begin
      desc_in  = desc_ff;
      held_in  = held_ff;
      step_in  = step_ff;
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (move) begin
         valid_in = 1'b1;
         data_in  = sel_byte;
         last_in  = (step_ff == STEP_END);
         user_in  = {(step_ff == STEP_END) & desc_ff.oversize, step_ff == end_step};
         step_in  = step_ff + 4'd1;
         if (step_ff == end_step) begin
            held_in = 1'b0;
         end
      end
      if (load) begin
         desc_in = desc;
         held_in = 1'b1;
         step_in = desc.first ? STEP_START : STEP_PAYLOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      step_ff <= step_in;
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ----- hdl/length_prefixed_xor_framer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_xor_framer
// Wraps a stream of payload bytes into length-prefixed frames with an XOR
// check byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one payload word per handshake: the byte and a payload length
//   that is read only on the first byte of a frame (zero counts as one).
//   rsp_* gives the framed byte stream: 0xA5, module byte, four little-endian
//   length bytes, the payload, the XOR of the payload and 0x5A. rsp_tlast
//   marks the end byte, rsp_tuser[0] the last word an input word causes and
//   rsp_tuser[1] an oversize frame (length + 8 above buffer_limit), shown with
//   the end byte. module_id and buffer_limit sit on the csr_* port at 0x0 and
//   0x4 and are sampled on a frame's first byte.
//   An accepted word is registered in the hold register; its output words
//   then pass through the single output register at one per cycle while
//   rsp_tready allows: one word for a middle payload byte, seven for a
//   first byte, three for a last byte and nine for a one-byte frame.
//   The next input word is taken in the cycle its predecessor's last output
//   word moves into the output register. When rsp_tready is low, the output
//   word holds and req_tready stays low while a word is held and its next
//   output word cannot move.
//   Reset clears the open frame, the running XOR and both valid flags and
//   loads module_id = 1, buffer_limit = 65535.
// ----------------------------------------------------------------------------
module length_prefixed_xor_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] payload_byte, [23:8] payload_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // frame_last
   output logic [1:0]  rsp_tuser,   // [0] run_last, [1] oversize
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lpxf_pkg::*;

   cfg_type  cfg;
   desc_type desc;
   logic     take_ok;
   logic     accept;

   // take a word whenever the emitter has room for its expansion
   assign req_tready = take_ok;
   assign accept     = req_tvalid & take_ok;

   lpxf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance frame state and describe the accepted word
   lpxf_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .payload_byte   (req_tdata[7:0]),
      .payload_length (req_tdata[23:8]),
      .cfg            (cfg),
      .desc           (desc)
   );

   // expand the described word into header, payload and trailer words
   lpxf_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .desc       (desc),
      .take_ok    (take_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- hdl/lpxf_checker.sv -----
// ----------------------------------------------------------------------------
// lpxf_checker
// Port-level checks on the framer's output stream.
// ----------------------------------------------------------------------------
module lpxf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [1:0] rsp_tuser
);
   import lpxf_pkg::*;

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("output word changed while stalled");

   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == END_BYTE)
      else $error("frame end without end byte");

   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("frame end not last of its run");

   a_oversize_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("oversize flag away from frame end");

endmodule

bind length_prefixed_xor_framer lpxf_checker u_lpxf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
